// File: src/rpa_pkg.sv
// Shared constants, codes and control types of the refcounted page allocator.
`default_nettype none
package rpa_pkg;

    localparam int PAGE_COUNT  = 32768;
    localparam int COUNT_WIDTH = 8;

    localparam int PAGE_W     = 15;
    localparam int FIRST_W    = 15;
    localparam int LIMIT_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int OPCODE_W   = 2;
    localparam int STATUS_W   = 3;

    localparam int ADDR_W  = $clog2(PAGE_COUNT);
    localparam int DEPTH_W = $clog2(PAGE_COUNT + 1);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    localparam logic [FIRST_W-1:0] FIRST_RESET = '0;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32768);

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = CFG_IDX_W'(1);

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REF_INC = 2'd2,
        OP_SEED    = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_NO_FREE     = 3'd1,
        ST_RANGE       = 3'd2,
        ST_ZERO        = 3'd3,
        ST_POPPED_BUSY = 3'd4,
        ST_SATURATED   = 3'd5
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;    // write zero to one count entry
        logic accept;   // take the input item, issue reads
        logic pop;      // popped page is on the stack read port
        logic commit;   // write back and load the result register
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: src/rpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: src/rpa_ctrl.sv
// Sequencer of the allocator: clear pass, accept, stack pop, write-back.
`default_nettype none
module rpa_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    input  wire logic [rpa_pkg::OPCODE_W-1:0] opcode,
    output logic                           req_ready,
    input  wire rpa_pkg::dp_stat_t         stat,
    output rpa_pkg::ctrl_cmd_t             cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_POP,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    // alloc needs the popped page before its count can be read
                    state_next = (rpa_pkg::opcode_t'(opcode) == rpa_pkg::OP_ALLOC) ?
                                 S_POP : S_EXEC;
                end
            end
            S_POP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready  = (state_reg == S_IDLE);
    assign cmd.clear  = (state_reg == S_CLEAR);
    assign cmd.accept = (state_reg == S_IDLE) && req_valid;
    assign cmd.pop    = (state_reg == S_POP);
    assign cmd.commit = (state_reg == S_EXEC) && stat.out_free;

endmodule
`default_nettype wire

// File: src/rpa_dpath.sv
// Datapath: count table, free stack, config registers, result register.
`default_nettype none
module rpa_dpath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire rpa_pkg::ctrl_cmd_t               cmd,
    output rpa_pkg::dp_stat_t                     stat,
    input  wire logic                             cfg_we,
    input  wire logic [rpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rpa_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [rpa_pkg::OPCODE_W-1:0]     opcode,
    input  wire logic [rpa_pkg::PAGE_W-1:0]       page_index,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_ready,
    output logic [rpa_pkg::STATUS_W-1:0]          status,
    output logic [rpa_pkg::PAGE_W-1:0]            result_page,
    output logic [rpa_pkg::COUNT_WIDTH-1:0]       ref_count,
    output logic                                  page_released
);

    localparam int AW = rpa_pkg::ADDR_W;
    localparam int DW = rpa_pkg::DEPTH_W;
    localparam int CW = rpa_pkg::COUNT_WIDTH;
    localparam int PW = rpa_pkg::PAGE_W;

    logic [rpa_pkg::FIRST_W-1:0] first_page_reg;
    logic [rpa_pkg::LIMIT_W-1:0] page_limit_reg;
    logic [AW-1:0]               clear_cnt_reg;
    logic [DW-1:0]               depth_reg;
    logic [DW-1:0]               depth_next;
    rpa_pkg::opcode_t            op_reg;
    logic [PW-1:0]               pg_reg;

    logic                        rsp_valid_reg;
    rpa_pkg::status_t            status_reg;
    logic [PW-1:0]               rpage_reg;
    logic [CW-1:0]               cnt_out_reg;
    logic                        rel_reg;

    // memory ports
    logic          cnt_we;
    logic [AW-1:0] cnt_waddr;
    logic [CW-1:0] cnt_wdata;
    logic [AW-1:0] cnt_raddr;
    logic [CW-1:0] cnt_rdata;
    logic          stk_we;
    logic [AW-1:0] stk_raddr;
    logic [PW-1:0] stk_rdata;

    // result of the current item
    rpa_pkg::status_t st;
    logic [PW-1:0]    rpage;
    logic [CW-1:0]    cnt_out;
    logic [CW-1:0]    cnt_new;
    logic             cnt_upd;
    logic             want_push;
    logic             push;
    logic             pop_dec;
    logic             pg_in_table;
    logic             in_range;
    logic             stack_full;

    assign pg_in_table = int'(pg_reg) < rpa_pkg::PAGE_COUNT;
    assign in_range    = (pg_reg >= first_page_reg)
                      && (rpa_pkg::LIMIT_W'(pg_reg) < page_limit_reg)
                      && pg_in_table;
    assign stack_full  = (depth_reg >= DW'(rpa_pkg::PAGE_COUNT));

    always_comb
    begin
        st        = rpa_pkg::ST_OK;
        rpage     = pg_reg;
        cnt_out   = '0;
        cnt_new   = cnt_rdata;
        cnt_upd   = 1'b0;
        want_push = 1'b0;
        pop_dec   = 1'b0;
        case (op_reg)
            rpa_pkg::OP_ALLOC:
            begin
                if (depth_reg == '0)
                begin
                    st    = rpa_pkg::ST_NO_FREE;
                    rpage = '0;
                end
                else
                begin
                    pop_dec = 1'b1;
                    if (!pg_in_table)
                    begin
                        st = rpa_pkg::ST_RANGE;
                    end
                    else if (cnt_rdata != '0)
                    begin
                        st      = rpa_pkg::ST_POPPED_BUSY;
                        cnt_out = cnt_rdata;
                    end
                    else
                    begin
                        cnt_new = rpa_pkg::CNT_ONE;
                        cnt_upd = 1'b1;
                        cnt_out = rpa_pkg::CNT_ONE;
                    end
                end
            end
            rpa_pkg::OP_FREE:
            begin
                if (!in_range)
                begin
                    st = rpa_pkg::ST_RANGE;
                end
                else if (cnt_rdata == '0)
                begin
                    st = rpa_pkg::ST_ZERO;
                end
                else
                begin
                    cnt_new   = cnt_rdata - CW'(1);
                    cnt_upd   = 1'b1;
                    cnt_out   = cnt_new;
                    want_push = (cnt_new == '0);
                end
            end
            rpa_pkg::OP_REF_INC:
            begin
                if (!pg_in_table)
                begin
                    st = rpa_pkg::ST_RANGE;
                end
                else if (cnt_rdata == rpa_pkg::CNT_MAX)
                begin
                    st      = rpa_pkg::ST_SATURATED;
                    cnt_out = cnt_rdata;
                end
                else
                begin
                    cnt_new = cnt_rdata + CW'(1);
                    cnt_upd = 1'b1;
                    cnt_out = cnt_new;
                end
            end
            rpa_pkg::OP_SEED:
            begin
                if (!in_range)
                begin
                    st = rpa_pkg::ST_RANGE;
                end
                else
                begin
                    // count forced to one, then released: always lands at zero
                    cnt_new   = '0;
                    cnt_upd   = 1'b1;
                    want_push = 1'b1;
                end
            end
            default:
            begin
                st = rpa_pkg::ST_OK;
            end
        endcase
    end

    // a push onto a full stack is dropped silently
    assign push = want_push && !stack_full;

    // count table port muxing
    assign cnt_we    = cmd.clear || (cmd.commit && cnt_upd);
    assign cnt_waddr = cmd.clear ? clear_cnt_reg : AW'(pg_reg);
    assign cnt_wdata = cmd.clear ? '0 : cnt_new;
    assign cnt_raddr = cmd.accept ? AW'(page_index) :
                       cmd.pop    ? AW'(stk_rdata)  : AW'(pg_reg);

    // stack top is always being read
    assign stk_we    = cmd.commit && push;
    assign stk_raddr = AW'(depth_reg - DW'(1));

    rpa_ram #(
        .WIDTH (CW),
        .DEPTH (rpa_pkg::PAGE_COUNT)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    rpa_ram #(
        .WIDTH (PW),
        .DEPTH (rpa_pkg::PAGE_COUNT)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (depth_reg[AW-1:0]),
        .wdata (pg_reg),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_comb
    begin
        depth_next = depth_reg;
        if (cmd.commit && push)
        begin
            depth_next = depth_reg + DW'(1);
        end
        else if (cmd.commit && pop_dec)
        begin
            depth_next = depth_reg - DW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_page_reg <= rpa_pkg::FIRST_RESET;
            page_limit_reg <= rpa_pkg::LIMIT_RESET;
            clear_cnt_reg  <= '0;
            depth_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == rpa_pkg::CFG_FIRST_PAGE))
            begin
                first_page_reg <= cfg_data[rpa_pkg::FIRST_W-1:0];
            end
            if (cfg_we && (cfg_index == rpa_pkg::CFG_PAGE_LIMIT))
            begin
                page_limit_reg <= cfg_data[rpa_pkg::LIMIT_W-1:0];
            end
            if (cmd.clear)
            begin
                clear_cnt_reg <= clear_cnt_reg + AW'(1);
            end
            depth_reg <= depth_next;
            if (cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg <= rpa_pkg::opcode_t'(opcode);
            pg_reg <= page_index;
        end
        else if (cmd.pop)
        begin
            pg_reg <= stk_rdata;
        end
        if (cmd.commit)
        begin
            status_reg  <= st;
            rpage_reg   <= rpage;
            cnt_out_reg <= cnt_out;
            rel_reg     <= push;
        end
    end

    assign stat.clear_last = (clear_cnt_reg == AW'(rpa_pkg::PAGE_COUNT - 1));
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign result_page   = rpage_reg;
    assign ref_count     = cnt_out_reg;
    assign page_released = rel_reg;

endmodule
`default_nettype wire

// File: src/refcounted_page_allocator.sv
// Free, ref-inc and seed read their count on accept and write back with the result; alloc
// first pops a page off the free stack. A new item is taken only after the last one writes back;
// the count table read and write-back through one synchronous RAM set this, plus the
// stack pop before alloc's count read. The result register lets the next item in while a result
// waits to be taken. Reset: asynchronous, active low. A clear pass then zeroes the count table,
// one entry at a time, with req_ready low; configuration writes are taken during it.
`default_nettype none
module refcounted_page_allocator (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [rpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rpa_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             req_valid,
    output logic                                  req_ready,
    input  wire logic [rpa_pkg::OPCODE_W-1:0]     opcode,
    input  wire logic [rpa_pkg::PAGE_W-1:0]       page_index,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_ready,
    output logic [rpa_pkg::STATUS_W-1:0]          status,
    output logic [rpa_pkg::PAGE_W-1:0]            result_page,
    output logic [rpa_pkg::COUNT_WIDTH-1:0]       ref_count,
    output logic                                  page_released
);

    rpa_pkg::ctrl_cmd_t cmd;
    rpa_pkg::dp_stat_t  stat;

    rpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .opcode    (opcode),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rpa_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .opcode        (opcode),
        .page_index    (page_index),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .status        (status),
        .result_page   (result_page),
        .ref_count     (ref_count),
        .page_released (page_released)
    );

endmodule
`default_nettype wire

// File: src/rpa_checker.sv
// Port-level checks of the allocator, bound to the top level.
`default_nettype none
module rpa_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             req_valid,
    input wire logic                             req_ready,
    input wire logic                             rsp_valid,
    input wire logic                             rsp_ready,
    input wire logic [rpa_pkg::STATUS_W-1:0]     status,
    input wire logic [rpa_pkg::PAGE_W-1:0]       result_page,
    input wire logic [rpa_pkg::COUNT_WIDTH-1:0]  ref_count,
    input wire logic                             page_released
);

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req_ready high right after an accepted item");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(result_page) && $stable(ref_count) && $stable(page_released))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status <= rpa_pkg::STATUS_W'(rpa_pkg::ST_SATURATED))
        else $error("undefined status code");

    a_no_free_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == rpa_pkg::STATUS_W'(rpa_pkg::ST_NO_FREE))
            |-> result_page == '0 && ref_count == '0 && !page_released)
        else $error("empty-stack alloc returned data");

    a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && page_released
            |-> status == rpa_pkg::STATUS_W'(rpa_pkg::ST_OK) && ref_count == '0)
        else $error("page released with error status or nonzero count");

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .status        (status),
    .result_page   (result_page),
    .ref_count     (ref_count),
    .page_released (page_released)
);
`default_nettype wire

// File: test/refcounted_page_allocator_tb.sv
// Self-checking testbench for the refcounted page allocator: directed table and random mix.
`timescale 1ns / 100ps
module refcounted_page_allocator_tb;

    localparam int PW = rpa_pkg::PAGE_W;
    localparam int CW = rpa_pkg::COUNT_WIDTH;

    typedef struct packed {
        rpa_pkg::status_t  status;
        logic [PW-1:0]     page;
        logic [CW-1:0]     count;
        logic              released;
    } page_outcome_t;

    typedef struct packed {
        rpa_pkg::opcode_t  op;
        logic [PW-1:0]     page;
        logic              typed;
        page_outcome_t     outcome;
    } directed_row_t;

    localparam page_outcome_t UNTYPED = '0;
    localparam int IDLE_PCT = 31;
    localparam int HOLD_CYCLES = 400;
    localparam int SAT_PAGE = 500;

    // Directed rows run with first_page = 8 and page_limit = 1000.
    localparam directed_row_t DIRECTED [24] = '{
        '{rpa_pkg::OP_ALLOC,   15'd0,     1'b1, '{rpa_pkg::ST_NO_FREE, 15'd0, 8'd0, 1'b0}},
        '{rpa_pkg::OP_ALLOC,   15'd32767, 1'b1, '{rpa_pkg::ST_NO_FREE, 15'd0, 8'd0, 1'b0}},
        '{rpa_pkg::OP_FREE,    15'd7,     1'b1, '{rpa_pkg::ST_RANGE, 15'd7, 8'd0, 1'b0}},
        '{rpa_pkg::OP_SEED,    15'd1000,  1'b1, '{rpa_pkg::ST_RANGE, 15'd1000, 8'd0, 1'b0}},
        '{rpa_pkg::OP_FREE,    15'd32767, 1'b1, '{rpa_pkg::ST_RANGE, 15'd32767, 8'd0, 1'b0}},
        '{rpa_pkg::OP_SEED,    15'd0,     1'b1, '{rpa_pkg::ST_RANGE, 15'd0, 8'd0, 1'b0}},
        '{rpa_pkg::OP_FREE,    15'd8,     1'b1, '{rpa_pkg::ST_ZERO, 15'd8, 8'd0, 1'b0}},
        '{rpa_pkg::OP_REF_INC, 15'd32767, 1'b1, '{rpa_pkg::ST_OK, 15'd32767, 8'd1, 1'b0}},
        '{rpa_pkg::OP_REF_INC, 15'd0,     1'b1, '{rpa_pkg::ST_OK, 15'd0, 8'd1, 1'b0}},
        '{rpa_pkg::OP_SEED,    15'd8,     1'b1, '{rpa_pkg::ST_OK, 15'd8, 8'd0, 1'b1}},
        '{rpa_pkg::OP_ALLOC,   15'd0,     1'b1, '{rpa_pkg::ST_OK, 15'd8, 8'd1, 1'b0}},
        '{rpa_pkg::OP_FREE,    15'd8,     1'b1, '{rpa_pkg::ST_OK, 15'd8, 8'd0, 1'b1}},
        '{rpa_pkg::OP_REF_INC, 15'd8,     1'b1, '{rpa_pkg::ST_OK, 15'd8, 8'd1, 1'b0}},
        '{rpa_pkg::OP_ALLOC,   15'd0,     1'b1, '{rpa_pkg::ST_POPPED_BUSY, 15'd8, 8'd1, 1'b0}},
        '{rpa_pkg::OP_SEED,    15'd999,   1'b1, '{rpa_pkg::ST_OK, 15'd999, 8'd0, 1'b1}},
        '{rpa_pkg::OP_REF_INC, 15'd999,   1'b0, UNTYPED},
        '{rpa_pkg::OP_REF_INC, 15'd999,   1'b0, UNTYPED},
        '{rpa_pkg::OP_SEED,    15'd999,   1'b0, UNTYPED},
        '{rpa_pkg::OP_ALLOC,   15'd0,     1'b0, UNTYPED},
        '{rpa_pkg::OP_ALLOC,   15'd0,     1'b0, UNTYPED},
        '{rpa_pkg::OP_FREE,    15'd999,   1'b0, UNTYPED},
        '{rpa_pkg::OP_ALLOC,   15'd21845, 1'b0, UNTYPED},
        '{rpa_pkg::OP_FREE,    15'd10922, 1'b0, UNTYPED},
        '{rpa_pkg::OP_ALLOC,   15'd0,     1'b0, UNTYPED}
    };

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [rpa_pkg::CFG_IDX_W-1:0]   cfg_index = rpa_pkg::CFG_FIRST_PAGE;
    logic [rpa_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                            req_valid = 1'b0;
    logic                            req_ready;
    logic [rpa_pkg::OPCODE_W-1:0]    opcode = rpa_pkg::OP_ALLOC;
    logic [PW-1:0]                   page_index = '0;
    logic                            rsp_valid;
    logic                            rsp_ready = 1'b0;
    logic [rpa_pkg::STATUS_W-1:0]    status;
    logic [PW-1:0]                   result_page;
    logic [CW-1:0]                   ref_count;
    logic                            page_released;

    // predictor state
    logic [CW-1:0]                   page_refs [rpa_pkg::PAGE_COUNT] = '{default: '0};
    logic [PW-1:0]                   free_pages [rpa_pkg::PAGE_COUNT];
    int                              free_top = 0;
    logic [rpa_pkg::FIRST_W-1:0]     cfg_first = rpa_pkg::FIRST_RESET;
    logic [rpa_pkg::LIMIT_W-1:0]     cfg_limit = rpa_pkg::LIMIT_RESET;

    page_outcome_t queued_outcomes [$];
    logic          steady = 1'b0;
    logic          rsp_hold_req = 1'b0;
    int            hold_left = 0;
    int            mismatches = 0;
    int            items_sent = 0;
    int            settings_used = 0;
    int            status_seen [6] = '{default: 0};

    refcounted_page_allocator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .opcode        (opcode),
        .page_index    (page_index),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .status        (status),
        .result_page   (result_page),
        .ref_count     (ref_count),
        .page_released (page_released)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic page_usable(logic [PW-1:0] pg);
        return pg >= cfg_first && pg < cfg_limit;
    endfunction

    // Decrement a live count; push the page when it hits zero and there is room.
    function automatic logic drop_reference(logic [PW-1:0] pg);
        page_refs[pg] = page_refs[pg] - 1'b1;
        if (page_refs[pg] != '0 || free_top >= rpa_pkg::PAGE_COUNT)
            return 1'b0;
        free_pages[free_top] = pg;
        free_top++;
        return 1'b1;
    endfunction

    function automatic page_outcome_t apply_page_op(rpa_pkg::opcode_t op,
                                                    logic [PW-1:0] pg);
        page_outcome_t r;
        r.status = rpa_pkg::ST_OK;
        r.page = pg;
        r.count = '0;
        r.released = 1'b0;
        case (op)
            rpa_pkg::OP_ALLOC:
            begin
                r.page = '0;
                if (free_top == 0)
                    r.status = rpa_pkg::ST_NO_FREE;
                else
                begin
                    free_top--;
                    r.page = free_pages[free_top];
                    if (page_refs[r.page] != '0)
                        r.status = rpa_pkg::ST_POPPED_BUSY;
                    else
                        page_refs[r.page] = rpa_pkg::CNT_ONE;
                    r.count = page_refs[r.page];
                end
            end
            rpa_pkg::OP_FREE:
            begin
                if (!page_usable(pg))
                    r.status = rpa_pkg::ST_RANGE;
                else if (page_refs[pg] == '0)
                    r.status = rpa_pkg::ST_ZERO;
                else
                begin
                    r.released = drop_reference(pg);
                    r.count = page_refs[pg];
                end
            end
            rpa_pkg::OP_REF_INC:
            begin
                // page_index cannot leave the table, so no range check here
                if (page_refs[pg] == rpa_pkg::CNT_MAX)
                    r.status = rpa_pkg::ST_SATURATED;
                else
                    page_refs[pg] = page_refs[pg] + 1'b1;
                r.count = page_refs[pg];
            end
            default:
            begin
                if (!page_usable(pg))
                    r.status = rpa_pkg::ST_RANGE;
                else
                begin
                    page_refs[pg] = rpa_pkg::CNT_ONE;
                    r.released = drop_reference(pg);
                    r.count = page_refs[pg];
                end
            end
        endcase
        return r;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic offer_item(input rpa_pkg::opcode_t op, input logic [PW-1:0] pg,
                              input logic typed, input page_outcome_t typed_outcome);
        page_outcome_t predicted;
        @(negedge clk);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_valid = 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < IDLE_PCT);
        end
        req_valid = 1'b1;
        opcode = op;
        page_index = pg;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = apply_page_op(op, pg);
        queued_outcomes.push_back(typed ? typed_outcome : predicted);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_valid = 1'b0;
        while (queued_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [rpa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rpa_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == rpa_pkg::CFG_FIRST_PAGE)
            cfg_first = data[rpa_pkg::FIRST_W-1:0];
        else
            cfg_limit = data;
    endtask

    task automatic set_window(input int first, input int limit);
        write_reg(rpa_pkg::CFG_FIRST_PAGE, rpa_pkg::CFG_DATA_W'(first));
        write_reg(rpa_pkg::CFG_PAGE_LIMIT, rpa_pkg::CFG_DATA_W'(limit));
        settings_used++;
    endtask

    // Mostly traffic on a small pool at the bottom of the window, some on its edges,
    // the rest anywhere in the page space.
    task automatic random_mix(input int n);
        int unsigned pick;
        rpa_pkg::opcode_t op;
        logic [PW-1:0] pg;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                op = rpa_pkg::OP_ALLOC;
            else if (pick < 50)
                op = rpa_pkg::OP_FREE;
            else if (pick < 72)
                op = rpa_pkg::OP_SEED;
            else
                op = rpa_pkg::OP_REF_INC;
            pick = $urandom_range(0, 99);
            if (pick < 75)
                pg = PW'(cfg_first + $urandom_range(0, 11));
            else if (pick < 85)
                pg = $urandom_range(0, 1) ? PW'(cfg_limit) : PW'(cfg_first - 1'b1);
            else
                pg = PW'($urandom);
            offer_item(op, pg, 1'b0, UNTYPED);
        end
    endtask

    always @(negedge clk)
    begin
        if (rsp_hold_req)
        begin
            rsp_hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready = 1'b0;
        end
        else
            rsp_ready = steady || $urandom_range(0, 99) >= IDLE_PCT;
    end

    always @(posedge clk)
    begin
        page_outcome_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_ready)
        begin
            if (queued_outcomes.size() == 0)
            begin
                $error("result with none expected: status %0d page %0d", status, result_page);
                mismatches++;
            end
            else
            begin
                want = queued_outcomes.pop_front();
                status_seen[want.status]++;
                compare_field("status", 32'(want.status), 32'(status));
                compare_field("result_page", 32'(want.page), 32'(result_page));
                compare_field("ref_count", 32'(want.count), 32'(ref_count));
                compare_field("page_released", 32'(want.released), 32'(page_released));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAIL refcounted_page_allocator");
        $finish;
    end

    initial
    begin
        int first;
        int span;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        set_window(8, 1000);
        foreach (DIRECTED[i])
            offer_item(DIRECTED[i].op, DIRECTED[i].page, DIRECTED[i].typed,
                       DIRECTED[i].outcome);

        // Walk one count up past saturation; the receiver stalls for a long
        // stretch at the start so the input backs up. Then some frees, no idling.
        rsp_hold_req = 1'b1;
        repeat (256) offer_item(rpa_pkg::OP_REF_INC, PW'(SAT_PAGE), 1'b0, UNTYPED);
        steady = 1'b1;
        repeat (24) offer_item(rpa_pkg::OP_FREE, PW'(SAT_PAGE), 1'b0, UNTYPED);
        steady = 1'b0;
        drain_results();

        for (int s = 0; s < 6; s++)
        begin
            case (s)
                0: set_window(0, rpa_pkg::PAGE_COUNT);
                1: set_window(rpa_pkg::PAGE_COUNT - 1, rpa_pkg::PAGE_COUNT);
                2: set_window(0, 1);
                3: set_window(300, 200);  // empty window
                default:
                begin
                    first = $urandom_range(0, rpa_pkg::PAGE_COUNT - 1);
                    span = $urandom_range(1, 64);
                    set_window(first, (first + span > rpa_pkg::PAGE_COUNT) ?
                               rpa_pkg::PAGE_COUNT : first + span);
                end
            endcase
            steady = (s == 0);
            random_mix(12);
            if (s == 1)
                drain_results();
            random_mix(12);
            drain_results();
        end
        steady = 1'b0;

        set_window(0, rpa_pkg::PAGE_COUNT);
        offer_item(rpa_pkg::OP_REF_INC, 15'd77, 1'b0, UNTYPED);
        offer_item(rpa_pkg::OP_FREE, 15'd77, 1'b0, UNTYPED);
        offer_item(rpa_pkg::OP_SEED, 15'd32767, 1'b0, UNTYPED);
        drain_results();
        repeat (8) @(posedge clk);

        $display("Covered %0d items under %0d register windows, count saturation and stalls.",
                 items_sent, settings_used);
        $display("Statuses seen: ok %0d, empty %0d, range %0d, zero %0d, busy pop %0d, sat %0d",
                 status_seen[rpa_pkg::ST_OK], status_seen[rpa_pkg::ST_NO_FREE],
                 status_seen[rpa_pkg::ST_RANGE], status_seen[rpa_pkg::ST_ZERO],
                 status_seen[rpa_pkg::ST_POPPED_BUSY], status_seen[rpa_pkg::ST_SATURATED]);
        if (mismatches == 0)
            $display("PASS refcounted_page_allocator");
        else
            $display("FAIL refcounted_page_allocator");
        $finish;
    end

endmodule
